// ===== hdl/http_proxy_request_classifier_macros.svh =====
// ----------------------------------------------------------------------------
// http_proxy_request_classifier_macros
// assertion macros shared by the classifier rtl
// ----------------------------------------------------------------------------
`ifndef HTTP_PROXY_REQUEST_CLASSIFIER_MACROS_SVH
`define HTTP_PROXY_REQUEST_CLASSIFIER_MACROS_SVH

// pre holds at one edge, post holds at the next
`define HPPC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

// expr holds at every edge out of reset
`define HPPC_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

`endif

// ===== hdl/hppc_pkg.sv =====
// ----------------------------------------------------------------------------
// hppc_pkg
// types, constants and method tables for the http proxy request classifier
// ----------------------------------------------------------------------------
package hppc_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] verdict;
    logic [2:0] method_index;
  } out_item_t;

  localparam int NUM_METHODS = 5;
  localparam int VER_CELLS   = 7;

  localparam logic [2:0] NO_METHOD = 3'd5;
  localparam logic [3:0] POS_SAT   = 4'd9;

  localparam logic [1:0] VERDICT_NONE    = 2'd0;
  localparam logic [1:0] VERDICT_ORIGIN  = 2'd1;
  localparam logic [1:0] VERDICT_NO_VER  = 2'd2;
  localparam logic [1:0] VERDICT_WITH_VER = 2'd3;

  localparam logic [7:0] SLASH_CHAR = 8'h2F;

  // "HTTP/1." with the newest byte lowest, final digit checked apart
  localparam logic [VER_CELLS*8-1:0] VER_PREFIX = 56'h485454502F312E;
  localparam logic [7:0] VER_DIGIT_0 = 8'h30;
  localparam logic [7:0] VER_DIGIT_1 = 8'h31;

  function automatic logic [3:0] method_len(input logic [2:0] idx);
    logic [3:0] len;
    case (idx)
      3'd0:    len = 4'd3;
      3'd1:    len = 4'd3;
      3'd2:    len = 4'd4;
      3'd3:    len = 4'd6;
      3'd4:    len = 4'd7;
      default: len = 4'd0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] method_char(input logic [2:0] idx, input logic [2:0] pos);
    logic [55:0] txt;
    case (idx)
      3'd0:    txt = {"GET", 32'h0};
      3'd1:    txt = {"PUT", 32'h0};
      3'd2:    txt = {"POST", 24'h0};
      3'd3:    txt = {"DELETE", 8'h0};
      3'd4:    txt = "CONNECT";
      default: txt = 56'h0;
    endcase
    return txt[55 - 8*pos -: 8];
  endfunction

endpackage

// ===== hdl/hppc_cell.sv =====
// ----------------------------------------------------------------------------
// hppc_cell
// one byte of the version window, shifts to its neighbor and compares
// ----------------------------------------------------------------------------
module hppc_cell (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       shift_en,
  input  logic       clear,
  input  logic [7:0] byte_in,
  input  logic [7:0] match_byte,
  output logic [7:0] byte_out,
  output logic       hit
);

  logic [7:0] byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      byte_r <= 8'h00;
    end else if (shift_en) begin
      byte_r <= byte_in;
    end
  end

  assign byte_out = byte_r;
  assign hit      = (byte_r == match_byte);

endmodule

// ===== hdl/http_proxy_request_classifier.sv =====
// ----------------------------------------------------------------------------
// http_proxy_request_classifier
// classifies a tcp payload as an http request by method and target form
// output: the result of a payload is registered and appears in the cycle after its last byte is taken
// throughput: one byte per cycle while out_valid is low or out_ready is high; the method compare
// is combinational and the version window has seven cells
// reset: synchronous active-low rst_n clears position, method and window state
// ----------------------------------------------------------------------------
`include "http_proxy_request_classifier_macros.svh"

module http_proxy_request_classifier (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  hppc_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output hppc_pkg::out_item_t out_item
);

  import hppc_pkg::*;

  logic [3:0]             pos_r;
  logic [NUM_METHODS-1:0] alive_r;
  logic                   slash_r;
  logic                   ver_found_r;
  logic                   out_valid_r;
  out_item_t              out_item_r;

  logic [3:0]             pos_nxt;
  logic [NUM_METHODS-1:0] alive_nxt;
  logic                   slash_nxt;
  logic                   ver_nxt;
  out_item_t              res_nxt;

  logic                   in_fire;
  logic                   shift_en;
  logic                   clear;
  logic [VER_CELLS:0][7:0] chain;
  logic [VER_CELLS-1:0]   cell_hit;
  logic                   found;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign shift_en = in_fire && !in_item.last_byte;
  assign clear    = in_fire && in_item.last_byte;
  assign chain[0] = in_item.data_byte;

  for (genvar g = 0; g < VER_CELLS; g++) begin : g_cell
    hppc_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .shift_en   (shift_en),
      .clear      (clear),
      .byte_in    (chain[g]),
      .match_byte (VER_PREFIX[8*g +: 8]),
      .byte_out   (chain[g+1]),
      .hit        (cell_hit[g])
    );
  end

  always_comb begin
    alive_nxt = alive_r;
    slash_nxt = slash_r;
    pos_nxt   = POS_SAT;
    if (pos_r < POS_SAT) begin
      pos_nxt = pos_r + 4'd1;
      for (int i = 0; i < NUM_METHODS; i++) begin
        if (alive_r[i]) begin
          if (pos_r < method_len(3'(i))) begin
            if (in_item.data_byte != method_char(3'(i), pos_r[2:0])) begin
              alive_nxt[i] = 1'b0;
            end
          end else if (pos_r == method_len(3'(i)) + 4'd1 &&
                       in_item.data_byte == SLASH_CHAR) begin
            slash_nxt = 1'b1;
          end
        end
      end
    end
    ver_nxt = ver_found_r || (&cell_hit && (in_item.data_byte == VER_DIGIT_0 ||
                                            in_item.data_byte == VER_DIGIT_1));
  end

  always_comb begin
    found                = 1'b0;
    res_nxt.verdict      = VERDICT_NONE;
    res_nxt.method_index = NO_METHOD;
    for (int i = 0; i < NUM_METHODS; i++) begin
      if (!found && alive_nxt[i] && pos_nxt >= method_len(3'(i)) + 4'd2) begin
        found                = 1'b1;
        res_nxt.method_index = 3'(i);
        res_nxt.verdict      = slash_nxt ? VERDICT_ORIGIN :
                               (ver_nxt ? VERDICT_WITH_VER : VERDICT_NO_VER);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= 4'd0;
      alive_r     <= '1;
      slash_r     <= 1'b0;
      ver_found_r <= 1'b0;
    end else if (clear) begin
      pos_r       <= 4'd0;
      alive_r     <= '1;
      slash_r     <= 1'b0;
      ver_found_r <= 1'b0;
    end else if (shift_en) begin
      pos_r       <= pos_nxt;
      alive_r     <= alive_nxt;
      slash_r     <= slash_nxt;
      ver_found_r <= ver_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (clear) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      out_item_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `HPPC_ASSERT_ALWAYS(a_pos_range, pos_r <= POS_SAT, "byte position past saturation")
  `HPPC_ASSERT_ALWAYS(a_none_pairs,
    !out_valid_r || ((out_item_r.verdict == VERDICT_NONE) ==
                     (out_item_r.method_index == NO_METHOD)),
    "verdict and method index disagree")
  `HPPC_ASSERT_NEXT(a_clear_state, clear,
    pos_r == 4'd0 && alive_r == '1 && !slash_r && !ver_found_r && out_valid_r,
    "state not cleared after last item")
  `HPPC_ASSERT_NEXT(a_pos_step, shift_en && pos_r < POS_SAT,
    pos_r == $past(pos_r) + 4'd1, "byte position did not advance")
  `HPPC_ASSERT_ALWAYS(a_ready_empty, out_valid_r || in_ready,
    "input stalled with empty output register")

endmodule

// ===== sim/tb_http_proxy_request_classifier.sv =====
// ----------------------------------------------------------------------------
// tb_http_proxy_request_classifier
// self-checking bench, one payload byte per item, checked against a byte model
// ----------------------------------------------------------------------------
module tb_http_proxy_request_classifier;
  timeunit 1ns;
  timeprecision 1ps;

  import hppc_pkg::*;

  localparam int M_GET     = 0;
  localparam int M_PUT     = 1;
  localparam int M_POST    = 2;
  localparam int M_DELETE  = 3;
  localparam int M_CONNECT = 4;

  localparam logic [63:0] HTTP_10 = "HTTP/1.0";
  localparam logic [63:0] HTTP_11 = "HTTP/1.1";
  localparam logic [7:0]  SPACE_CHAR = 8'h20;

  localparam int HOLD_CYCLES   = 64;
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_TARGET = 650;
  localparam int TOTAL_TARGET  = 750;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  // byte-level classifier state
  logic [3:0]  seen_count = '0;
  logic [4:0]  verbs_alive = '1;
  logic        slash_target = 1'b0;
  logic [55:0] byte_history = '0;
  logic        version_seen = 1'b0;

  out_item_t   verdicts_due[$];
  logic [7:0]  payload[$];

  logic      sender_idle = 1'b1;
  logic      receiver_idle = 1'b1;
  logic      hold_request = 1'b0;
  int        bytes_sent = 0;
  int        payloads_sent = 0;
  int        verdicts_checked = 0;
  int        input_stall_cycles = 0;
  int        mismatches = 0;
  int        quiet_cycles = 0;
  logic      has_verdict;
  out_item_t predicted;
  out_item_t oldest;

  http_proxy_request_classifier u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic string verb_text(input int m);
    string s;
    case (m)
      M_GET:     s = "GET";
      M_PUT:     s = "PUT";
      M_POST:    s = "POST";
      M_DELETE:  s = "DELETE";
      M_CONNECT: s = "CONNECT";
      default:   s = "";
    endcase
    return s;
  endfunction

  function automatic void classify_byte(input in_item_t it, output logic got,
                                        output out_item_t res);
    logic [63:0] window;
    logic [4:0]  alive;
    logic        slash;
    logic        ver;
    logic        found;
    int          count;
    int          vlen;
    string       s;
    window = {byte_history, it.data_byte};
    ver    = version_seen || window == HTTP_10 || window == HTTP_11;
    alive  = verbs_alive;
    slash  = slash_target;
    found  = 1'b0;
    res.verdict      = VERDICT_NONE;
    res.method_index = NO_METHOD;
    if (seen_count < POS_SAT) begin
      for (int i = M_GET; i <= M_CONNECT; i++) begin
        s    = verb_text(i);
        vlen = s.len();
        if (alive[i]) begin
          if (int'(seen_count) < vlen) begin
            if (it.data_byte != s[int'(seen_count)]) alive[i] = 1'b0;
          end else if (int'(seen_count) == vlen + 1 && it.data_byte == SLASH_CHAR) begin
            slash = 1'b1;
          end
        end
      end
      count = int'(seen_count) + 1;
    end else begin
      count = int'(POS_SAT);
    end
    got = it.last_byte;
    if (!it.last_byte) begin
      seen_count   = 4'(count);
      verbs_alive  = alive;
      slash_target = slash;
      byte_history = window[55:0];
      version_seen = ver;
    end else begin
      for (int i = M_GET; i <= M_CONNECT; i++) begin
        s = verb_text(i);
        if (!found && alive[i] && count >= s.len() + 2) begin
          found            = 1'b1;
          res.method_index = 3'(i);
          res.verdict      = slash ? VERDICT_ORIGIN :
                             (ver ? VERDICT_WITH_VER : VERDICT_NO_VER);
        end
      end
      seen_count   = '0;
      verbs_alive  = '1;
      slash_target = 1'b0;
      byte_history = '0;
      version_seen = 1'b0;
    end
  endfunction

  // result check first, then prediction of the item taken at this edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (verdicts_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, got verdict %0d method %0d",
                   $time, out_item.verdict, out_item.method_index);
          mismatches++;
        end else begin
          oldest = verdicts_due.pop_front();
          if (out_item.verdict !== oldest.verdict) begin
            $display("%0t: verdict mismatch, expected %0d, got %0d",
                     $time, oldest.verdict, out_item.verdict);
            mismatches++;
          end
          if (out_item.method_index !== oldest.method_index) begin
            $display("%0t: method_index mismatch, expected %0d, got %0d",
                     $time, oldest.method_index, out_item.method_index);
            mismatches++;
          end
        end
        verdicts_checked++;
      end
      if (in_valid && in_ready) begin
        classify_byte(in_item, has_verdict, predicted);
        if (has_verdict) verdicts_due.push_back(predicted);
      end
      if (in_valid && !in_ready) input_stall_cycles++;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("FAIL http_proxy_request_classifier");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // receiver: random stall bursts, one long hold on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (receiver_idle && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 5)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // entered and left at a falling edge
  task automatic send_item(input in_item_t it);
    if (sender_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_payload();
    in_item_t it;
    for (int k = 0; k < payload.size(); k++) begin
      it.data_byte = payload[k];
      it.last_byte = (k == payload.size() - 1);
      send_item(it);
    end
    payloads_sent++;
  endtask

  task automatic append_text(input string s);
    for (int k = 0; k < s.len(); k++) payload.push_back(s[k]);
  endtask

  task automatic make_request();
    int m;
    int keep;
    m = $urandom_range(M_GET, M_CONNECT);
    payload.delete();
    append_text(verb_text(m));
    if ($urandom_range(0, 7) == 0)
      payload[$urandom_range(0, payload.size() - 1)] = 8'($urandom_range(0, 255));
    payload.push_back($urandom_range(0, 5) == 0 ? 8'($urandom_range(0, 255)) : SPACE_CHAR);
    if ($urandom_range(0, 1)) payload.push_back(SLASH_CHAR);
    repeat ($urandom_range(0, 5)) payload.push_back(8'($urandom_range(8'h21, 8'h7E)));
    if ($urandom_range(0, 1)) begin
      payload.push_back(SPACE_CHAR);
      for (int k = 0; k < 7; k++) payload.push_back(HTTP_10[63 - 8*k -: 8]);
      case ($urandom_range(0, 3))
        0:       payload.push_back(8'($urandom_range(0, 255)));
        1:       payload.push_back(HTTP_10[7:0]);
        default: payload.push_back(HTTP_11[7:0]);
      endcase
    end
    repeat ($urandom_range(0, 3)) payload.push_back(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 7) == 0) begin
      keep = $urandom_range(1, payload.size());
      while (payload.size() > keep) payload.delete(payload.size() - 1);
    end
  endtask

  task automatic make_noise();
    payload.delete();
    repeat ($urandom_range(1, 10))
      payload.push_back($urandom_range(0, 3) == 0 ? 8'h00 : 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 3) == 0) begin
      for (int k = 0; k < 8; k++) payload.push_back(HTTP_11[63 - 8*k -: 8]);
      payload.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_directed_cases();
    payload.delete();
    payload.push_back(8'h00);
    send_payload();
    payload.delete();
    payload.push_back(8'hFF);
    send_payload();
    payload.delete();
    append_text("GET /");
    send_payload();
    // method bytes match but the payload is too short
    payload.delete();
    append_text("PUT");
    send_payload();
    // proxy target with version, past the position saturation
    payload.delete();
    append_text("POST xHTTP/1.0");
    send_payload();
  endtask

  task automatic test_output_hold();
    hold_request = 1'b1;
    repeat (10) begin
      payload.delete();
      append_text("GET /");
      send_payload();
    end
  endtask

  task automatic test_random_traffic(input int target);
    while (bytes_sent < target) begin
      if ($urandom_range(0, 3) == 0) make_noise();
      else make_request();
      send_payload();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_cases();
    test_output_hold();
    test_random_traffic(RANDOM_TARGET);
    sender_idle   = 1'b0;
    receiver_idle = 1'b0;
    test_random_traffic(TOTAL_TARGET);

    in_valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("sent %0d bytes in %0d payloads, checked %0d verdicts",
             bytes_sent, payloads_sent, verdicts_checked);
    $display("input held off for %0d cycles under output backpressure",
             input_stall_cycles);
    if (mismatches == 0) begin
      $display("PASS http_proxy_request_classifier");
    end else begin
      $display("FAIL http_proxy_request_classifier");
    end
    $finish;
  end

endmodule
